>>> hw/rtl/sparse_weighted_feature_aggregate_core_macros.svh
// Assertion macros shared by the aggregation core RTL.
`ifndef SPARSE_WEIGHTED_FEATURE_AGGREGATE_CORE_MACROS_SVH
`define SPARSE_WEIGHTED_FEATURE_AGGREGATE_CORE_MACROS_SVH

// Same-cycle implication, clocked on clk, off while rst_n is low.
`define SWFA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk, off while rst_n is low.
`define SWFA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/swfa_pkg.sv
// Shared types and constants for the sparse weighted feature aggregation core.
package swfa_pkg;

    // Field widths
    localparam int unsigned DATA_W   = 32;
    localparam int unsigned PROD_W   = 2 * DATA_W;
    localparam int unsigned FRAC_W   = 24;
    localparam int unsigned VERTEX_W = 10;
    localparam int unsigned GROUP_W  = 4;

    // Feature lanes carried by one word on the ports
    localparam int unsigned FEAT_FIELDS = 4;

    // Default sizing
    localparam int unsigned DEF_NUM_VERTICES = 1024;
    localparam int unsigned DEF_NUM_GROUPS   = 16;
    localparam int unsigned DEF_LANES        = 4;

    // Action codes
    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_ACCUM = 1'b1;

    // Control from the sequencer to every lane
    typedef struct packed {
        logic mul_en;   // capture coef * feat
        logic accum;    // 1: add rounded product, 0: load feature
    } lane_ctl_t;

endpackage

>>> hw/rtl/swfa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module swfa_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/swfa_lane.sv
// One accumulator lane: registered multiply, Q8.24 rounding, saturating add.
module swfa_lane (
    input  logic                                clk,
    input  swfa_pkg::lane_ctl_t                 ctl,
    input  logic signed [swfa_pkg::DATA_W-1:0]  coef,
    input  logic signed [swfa_pkg::DATA_W-1:0]  feat,
    input  logic signed [swfa_pkg::DATA_W-1:0]  old_val,
    output logic signed [swfa_pkg::DATA_W-1:0]  new_val
);
    import swfa_pkg::*;

    localparam int unsigned RND_W = PROD_W - FRAC_W;
    localparam int unsigned SUM_W = RND_W + 1;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [PROD_W-1:0] biased;
    logic signed [RND_W-1:0]  rnd;
    logic signed [SUM_W-1:0]  sum;
    logic signed [DATA_W-1:0] sat;
    logic                     ovf;

    // Exact Q16.48 product
    assign prod_next = coef * feat;

    always_ff @(posedge clk)
    begin
        if (ctl.mul_en)
        begin
            prod_reg <= prod_next;
        end
    end

    // Round half up to Q8.24: add half an LSB, floor by arithmetic shift
    assign biased = prod_reg + (PROD_W'(1) <<< (FRAC_W - 1));
    assign rnd    = biased[PROD_W-1:FRAC_W];

    // Full-width add, then clamp to 32 bits
    assign sum = SUM_W'(old_val) + SUM_W'(rnd);
    assign ovf = (sum[SUM_W-1:DATA_W-1] != {(SUM_W-DATA_W+1){1'b0}}) &&
                 (sum[SUM_W-1:DATA_W-1] != {(SUM_W-DATA_W+1){1'b1}});

    always_comb
    begin
        if (!ovf)
        begin
            sat = sum[DATA_W-1:0];
        end
        else if (sum[SUM_W-1])
        begin
            sat = {1'b1, {(DATA_W-1){1'b0}}};
        end
        else
        begin
            sat = {1'b0, {(DATA_W-1){1'b1}}};
        end
    end

    assign new_val = ctl.accum ? sat : feat;

endmodule

>>> hw/rtl/sparse_weighted_feature_aggregate_core.sv
// Sparse weighted feature aggregation core: top level with sequencer and row RAM.
// An accepted word steps through ADDR (row read), MUL (multiply) and ACC (write-back).
// A new word is taken only while busy is low, in IDLE or ACC; done is registered from ACC.
// done is a one-cycle strobe; results hold until the next done; the receiver cannot stall.
// Reset (rst_n low, async) clears the sequencer and done; row RAM contents stay undefined.
`include "sparse_weighted_feature_aggregate_core_macros.svh"

module sparse_weighted_feature_aggregate_core #(
    parameter int unsigned NUM_VERTICES = swfa_pkg::DEF_NUM_VERTICES,
    parameter int unsigned NUM_GROUPS   = swfa_pkg::DEF_NUM_GROUPS,
    parameter int unsigned LANES        = swfa_pkg::DEF_LANES
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 action,
    input  logic [swfa_pkg::VERTEX_W-1:0]        vertex,
    input  logic [swfa_pkg::GROUP_W-1:0]         group,
    input  logic signed [swfa_pkg::DATA_W-1:0]   coef,
    input  logic signed [swfa_pkg::DATA_W-1:0]   feat_a,
    input  logic signed [swfa_pkg::DATA_W-1:0]   feat_b,
    input  logic signed [swfa_pkg::DATA_W-1:0]   feat_c,
    input  logic signed [swfa_pkg::DATA_W-1:0]   feat_d,
    output logic                                 done,
    output logic [swfa_pkg::VERTEX_W-1:0]        out_vertex,
    output logic [swfa_pkg::GROUP_W-1:0]         out_group,
    output logic signed [swfa_pkg::DATA_W-1:0]   sum_a,
    output logic signed [swfa_pkg::DATA_W-1:0]   sum_b,
    output logic signed [swfa_pkg::DATA_W-1:0]   sum_c,
    output logic signed [swfa_pkg::DATA_W-1:0]   sum_d
);
    import swfa_pkg::*;

    localparam int unsigned DEPTH  = NUM_VERTICES * NUM_GROUPS;
    localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned ROW_W  = LANES * DATA_W;

    // Reciprocals for the index wrap: quotient estimate is exact or one low
    localparam int unsigned V_SH   = 2 * VERTEX_W;
    localparam int unsigned G_SH   = 2 * GROUP_W;
    localparam int unsigned V_REC  = (1 << V_SH) / NUM_VERTICES;
    localparam int unsigned G_REC  = (1 << G_SH) / NUM_GROUPS;
    localparam int unsigned VP_W   = V_SH + VERTEX_W + 1;
    localparam int unsigned GP_W   = G_SH + GROUP_W + 1;
    localparam int unsigned VQN_W  = VERTEX_W + 17;
    localparam int unsigned GQN_W  = GROUP_W + 9;
    localparam int unsigned A_W    = 25;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_ADDR = 4'b0010,
        ST_MUL  = 4'b0100,
        ST_ACC  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic accept;

    // Latched word
    logic                      action_reg;
    logic [VERTEX_W-1:0]       vertex_reg;
    logic [GROUP_W-1:0]        group_reg;
    logic signed [DATA_W-1:0]  coef_reg;
    logic signed [DATA_W-1:0]  feat_reg [FEAT_FIELDS];
    logic signed [DATA_W-1:0]  feat_in  [FEAT_FIELDS];
    logic [VERTEX_W-1:0]       vq_reg;
    logic [GROUP_W-1:0]        gq_reg;
    logic [VP_W-1:0]           vprod;
    logic [GP_W-1:0]           gprod;

    // Index wrap
    logic [VQN_W-1:0]          vqn;
    logic [GQN_W-1:0]          gqn;
    logic [VERTEX_W:0]         vrem_raw;
    logic [GROUP_W:0]          grem_raw;
    logic [VERTEX_W:0]         vrem;
    logic [GROUP_W:0]          grem;
    logic [A_W-1:0]            row_lin;
    logic [ADDR_W-1:0]         row_addr;
    logic [ADDR_W-1:0]         addr_reg;

    // RAM and lanes
    logic                      ram_we;
    logic                      ram_re;
    logic [ROW_W-1:0]          ram_rdata;
    logic [ROW_W-1:0]          ram_wdata;
    lane_ctl_t                 lane_ctl;
    logic signed [DATA_W-1:0]  lane_new [LANES];

    // Result registers
    logic                      done_reg;
    logic [VERTEX_W-1:0]       out_vertex_reg;
    logic [GROUP_W-1:0]        out_group_reg;
    logic signed [DATA_W-1:0]  sum_reg [FEAT_FIELDS];

    assign accept = start && !busy;
    assign busy   = !((state_reg == ST_IDLE) || (state_reg == ST_ACC));

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: state_next = accept ? ST_ADDR : ST_IDLE;
            ST_ADDR: state_next = ST_MUL;
            ST_MUL:  state_next = ST_ACC;
            ST_ACC:  state_next = accept ? ST_ADDR : ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Capture the word and the quotient estimates
    assign feat_in[0] = feat_a;
    assign feat_in[1] = feat_b;
    assign feat_in[2] = feat_c;
    assign feat_in[3] = feat_d;

    assign vprod = VP_W'(vertex) * VP_W'(V_REC);
    assign gprod = GP_W'(group) * GP_W'(G_REC);

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            action_reg <= action;
            vertex_reg <= vertex;
            group_reg  <= group;
            coef_reg   <= coef;
            for (int i = 0; i < FEAT_FIELDS; i++)
            begin
                feat_reg[i] <= feat_in[i];
            end
            vq_reg <= vprod[V_SH +: VERTEX_W];
            gq_reg <= gprod[G_SH +: GROUP_W];
        end
    end

    // Remainder with one correction step, then row address
    assign vqn      = VQN_W'(vq_reg) * VQN_W'(NUM_VERTICES);
    assign gqn      = GQN_W'(gq_reg) * GQN_W'(NUM_GROUPS);
    assign vrem_raw = {1'b0, vertex_reg} - vqn[VERTEX_W:0];
    assign grem_raw = {1'b0, group_reg} - gqn[GROUP_W:0];

    always_comb
    begin
        if (VQN_W'(vrem_raw) >= VQN_W'(NUM_VERTICES))
        begin
            vrem = vrem_raw - (VERTEX_W + 1)'(NUM_VERTICES);
        end
        else
        begin
            vrem = vrem_raw;
        end
        if (GQN_W'(grem_raw) >= GQN_W'(NUM_GROUPS))
        begin
            grem = grem_raw - (GROUP_W + 1)'(NUM_GROUPS);
        end
        else
        begin
            grem = grem_raw;
        end
    end

    assign row_lin  = A_W'(vrem) * A_W'(NUM_GROUPS) + A_W'(grem);
    assign row_addr = row_lin[ADDR_W-1:0];

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_ADDR)
        begin
            addr_reg <= row_addr;
        end
    end

    // Row storage
    assign ram_re = (state_reg == ST_ADDR);
    assign ram_we = (state_reg == ST_ACC);

    swfa_ram #(
        .WIDTH (ROW_W),
        .DEPTH (DEPTH)
    ) u_row_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (addr_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (row_addr),
        .rdata (ram_rdata)
    );

    // Lanes
    assign lane_ctl.mul_en = (state_reg == ST_MUL);
    assign lane_ctl.accum  = (action_reg == ACT_ACCUM);

    for (genvar l = 0; l < LANES; l++)
    begin : g_lane
        logic signed [DATA_W-1:0] lane_feat;

        if (l < FEAT_FIELDS)
        begin : g_fed
            assign lane_feat = feat_reg[l];
        end
        else
        begin : g_zero
            assign lane_feat = '0;
        end

        swfa_lane u_lane (
            .clk     (clk),
            .ctl     (lane_ctl),
            .coef    (coef_reg),
            .feat    (lane_feat),
            .old_val (ram_rdata[l*DATA_W +: DATA_W]),
            .new_val (lane_new[l])
        );

        assign ram_wdata[l*DATA_W +: DATA_W] = lane_new[l];
    end

    // Merge lanes into the result word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (state_reg == ST_ACC);
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_ACC)
        begin
            out_vertex_reg <= vertex_reg;
            out_group_reg  <= group_reg;
        end
    end

    for (genvar f = 0; f < FEAT_FIELDS; f++)
    begin : g_sum
        if (f < LANES)
        begin : g_live
            always_ff @(posedge clk)
            begin
                if (state_reg == ST_ACC)
                begin
                    sum_reg[f] <= lane_new[f];
                end
            end
        end
        else
        begin : g_absent
            assign sum_reg[f] = '0;
        end
    end

    assign done       = done_reg;
    assign out_vertex = out_vertex_reg;
    assign out_group  = out_group_reg;
    assign sum_a      = sum_reg[0];
    assign sum_b      = sum_reg[1];
    assign sum_c      = sum_reg[2];
    assign sum_d      = sum_reg[3];

    // Checks
    `SWFA_ASSERT_NEXT(a_accept_to_addr, accept, state_reg == ST_ADDR, "accepted word skipped address stage")
    `SWFA_ASSERT_NEXT(a_acc_to_done, state_reg == ST_ACC, done_reg, "write-back gave no done strobe")
    `SWFA_ASSERT_NEXT(a_done_single, done_reg, !done_reg, "done strobe held two cycles")
    `SWFA_ASSERT_NOW(a_ram_port_excl, ram_we, !ram_re, "row read and write in the same cycle")

endmodule
